[src/security_label_target_select_assert.svh]
// Assertion macros used by the port-level checker of the security label target select block.
`ifndef SECURITY_LABEL_TARGET_SELECT_ASSERT_SVH
`define SECURITY_LABEL_TARGET_SELECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/slts_pkg.sv]
// Types and constants of the security label target select block.
package slts_pkg;

	localparam int LABEL_W   = 32;
	localparam int INDEX_W   = 4;
	localparam int DIMS_W    = 4;

	localparam int DEF_MAX_DIMS    = 8;
	localparam int DEF_CODE_BITS   = 4;
	localparam int DEF_TABLE_DEPTH = 16;

	localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd8;

	localparam int CODE_BOTTOM = 0;
	localparam int CODE_TOP    = 1;

	typedef enum logic [1:0] {
		OP_STORE = 2'd0,
		OP_CLEAR = 2'd1,
		OP_CMP   = 2'd2,
		OP_FIND  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REL_EQUAL = 2'd0,
		REL_BELOW = 2'd1,
		REL_ABOVE = 2'd2,
		REL_NONE  = 2'd3
	} rel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_SCAN,
		S_BEST,
		S_EMIT
	} state_t;

endpackage

[src/slts_channels.sv]
// Handshake channel interfaces: request, response and configuration.
interface slts_req_if;
	import slts_pkg::*;
	logic                 valid;
	logic                 ready;
	op_t                  opcode;
	logic [INDEX_W-1:0]   index;
	logic [LABEL_W-1:0]   label_a;
	logic [LABEL_W-1:0]   label_b;
	modport source (output valid, opcode, index, label_a, label_b, input ready);
	modport sink   (input valid, opcode, index, label_a, label_b, output ready);
endinterface

interface slts_rsp_if;
	import slts_pkg::*;
	logic                 valid;
	logic                 ready;
	rel_t                 relation;
	logic                 found;
	logic [INDEX_W-1:0]   entry_index;
	modport source (output valid, relation, found, entry_index, input ready);
	modport sink   (input valid, relation, found, entry_index, output ready);
endinterface

interface slts_cfg_if;
	import slts_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [DIMS_W-1:0]    active_dims;
	modport source (output valid, active_dims, input ready);
	modport sink   (input valid, active_dims, output ready);
endinterface

[src/security_label_target_select.sv]
// Top level: label table, find sequencer and output register around one shared comparator.
// Store and clear go from the accepting state to the emit state; compare passes S_CMP first.
// Find scans every table entry in turn, adding a best state for each qualifying entry after
// the first, as the single comparator must then also relate the kept best to that entry.
// A new item is taken once the previous result sits in the output register.
// Reset clears the valid bits, the sequencer and the output; active_dims returns to 8.
module security_label_target_select #(
	parameter int MAX_DIMS    = slts_pkg::DEF_MAX_DIMS,
	parameter int CODE_BITS   = slts_pkg::DEF_CODE_BITS,
	parameter int TABLE_DEPTH = slts_pkg::DEF_TABLE_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	slts_req_if.sink   req,
	slts_rsp_if.source rsp,
	slts_cfg_if.sink   cfg
);
	import slts_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	state_t               state_q;
	state_t               state_d;
	logic [IDX_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     cnt_d;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [DIMS_W-1:0]    active_dims_q;
	logic [LABEL_W-1:0]   label_mem [TABLE_DEPTH];
	logic [LABEL_W-1:0]   rd_data_q;
	logic [LABEL_W-1:0]   op_a_q;
	logic [LABEL_W-1:0]   op_b_q;
	logic [LABEL_W-1:0]   best_q;
	rel_t                 rel_q;
	logic                 found_q;
	logic [IDX_W-1:0]     hit_q;
	logic                 out_valid_q;
	rel_t                 out_rel_q;
	logic                 out_found_q;
	logic [INDEX_W-1:0]   out_index_q;

	logic                 accept;
	logic                 store_ok;
	logic [IDX_W-1:0]     wr_addr;
	logic [LABEL_W-1:0]   unit_a;
	logic [LABEL_W-1:0]   unit_b;
	rel_t                 unit_rel;
	logic                 take;
	logic                 load_out;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign store_ok  = (32'(req.index) < TABLE_DEPTH);
	assign wr_addr   = IDX_W'(req.index);
	assign cfg.ready = 1'b1;

	assign rsp.valid       = out_valid_q;
	assign rsp.relation    = out_rel_q;
	assign rsp.found       = out_found_q;
	assign rsp.entry_index = out_index_q;

	// The comparator relates the two request labels in S_CMP and query against entry while
	// scanning, and the kept best against the same entry in the cycle after any later qualifying hit.
	assign unit_a = (state_q == S_BEST) ? best_q : op_a_q;
	assign unit_b = (state_q == S_CMP) ? op_b_q : rd_data_q;

	slts_relate #(
		.MAX_DIMS  (MAX_DIMS),
		.CODE_BITS (CODE_BITS)
	) u_relate (
		.a    (unit_a),
		.b    (unit_b),
		.dims (active_dims_q),
		.rel  (unit_rel)
	);

	always_comb begin
		logic cand;
		logic advance;
		state_d  = state_q;
		cnt_d    = cnt_q;
		take     = 1'b0;
		load_out = 1'b0;
		advance  = 1'b0;
		cand     = valid_q[cnt_q] && (unit_rel == REL_EQUAL || unit_rel == REL_BELOW);
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.opcode)
						OP_STORE, OP_CLEAR: state_d = S_EMIT;
						OP_CMP:             state_d = S_CMP;
						OP_FIND: begin
							state_d = S_SCAN;
							cnt_d   = '0;
						end
						default:            state_d = S_EMIT;
					endcase
				end
			end
			S_CMP: state_d = S_EMIT;
			S_SCAN: begin
				if (cand && found_q) begin
					state_d = S_BEST;
				end else begin
					take    = cand;
					advance = 1'b1;
				end
			end
			S_BEST: begin
				take    = (unit_rel == REL_ABOVE);
				advance = 1'b1;
			end
			S_EMIT: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (advance) begin
			if (cnt_q == LAST_IDX) begin
				state_d = S_EMIT;
			end else begin
				cnt_d   = cnt_q + 1'b1;
				state_d = S_SCAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			valid_q       <= '0;
			active_dims_q <= DIMS_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cfg.valid && cfg.ready) begin
				active_dims_q <= cfg.active_dims;
			end
			if (accept && req.opcode == OP_STORE && store_ok) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (accept && req.opcode == OP_CLEAR) begin
				valid_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Table storage: one write port at accept, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (accept && req.opcode == OP_STORE && store_ok) begin
			label_mem[wr_addr] <= req.label_a;
		end
		rd_data_q <= label_mem[cnt_d];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_a_q  <= req.label_a;
			op_b_q  <= req.label_b;
			rel_q   <= REL_EQUAL;
			found_q <= 1'b0;
			hit_q   <= '0;
		end else begin
			if (state_q == S_CMP) begin
				rel_q <= unit_rel;
			end
			if (take) begin
				best_q  <= rd_data_q;
				hit_q   <= cnt_q;
				found_q <= 1'b1;
			end
		end
		if (load_out) begin
			out_rel_q   <= rel_q;
			out_found_q <= found_q;
			out_index_q <= INDEX_W'(hit_q);
		end
	end

endmodule

[src/slts_relate.sv]
// Shared label comparator: relates two packed labels over the active components.
module slts_relate #(
	parameter int MAX_DIMS  = slts_pkg::DEF_MAX_DIMS,
	parameter int CODE_BITS = slts_pkg::DEF_CODE_BITS
) (
	input  logic [slts_pkg::LABEL_W-1:0] a,
	input  logic [slts_pkg::LABEL_W-1:0] b,
	input  logic [slts_pkg::DIMS_W-1:0]  dims,
	output slts_pkg::rel_t               rel
);
	import slts_pkg::*;

	localparam int EXT_W  = MAX_DIMS * CODE_BITS + LABEL_W;
	localparam int DCNT_W = DIMS_W + 1;

	logic [EXT_W-1:0]     a_ext;
	logic [EXT_W-1:0]     b_ext;
	logic [DCNT_W-1:0]    dims_eff;
	logic                 any_below;
	logic                 any_above;
	logic                 any_none;

	// Components past the top of the label read as bottom through zero extension.
	assign a_ext = EXT_W'(a);
	assign b_ext = EXT_W'(b);

	assign dims_eff = ({1'b0, dims} > DCNT_W'(MAX_DIMS)) ? DCNT_W'(MAX_DIMS) : {1'b0, dims};

	always_comb begin
		logic [CODE_BITS-1:0] x;
		logic [CODE_BITS-1:0] y;
		any_below = 1'b0;
		any_above = 1'b0;
		any_none  = 1'b0;
		for (int i = 0; i < MAX_DIMS; i++) begin
			x = a_ext[i*CODE_BITS +: CODE_BITS];
			y = b_ext[i*CODE_BITS +: CODE_BITS];
			if (DCNT_W'(i) < dims_eff && x != y) begin
				if (x == CODE_BITS'(CODE_BOTTOM) || y == CODE_BITS'(CODE_TOP)) begin
					any_below = 1'b1;
				end else if (x == CODE_BITS'(CODE_TOP) || y == CODE_BITS'(CODE_BOTTOM)) begin
					any_above = 1'b1;
				end else begin
					any_none = 1'b1;
				end
			end
		end
	end

	always_comb begin
		priority if (dims_eff == '0 || any_none || (any_below && any_above)) begin
			rel = REL_NONE;
		end else if (any_below) begin
			rel = REL_BELOW;
		end else if (any_above) begin
			rel = REL_ABOVE;
		end else begin
			rel = REL_EQUAL;
		end
	end

endmodule

[src/slts_checker.sv]
// Port-level checker for the security label target select block, bound to the top level.
`include "security_label_target_select_assert.svh"

module slts_port_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input slts_pkg::rel_t                 rsp_relation,
	input logic                           rsp_found,
	input logic [slts_pkg::INDEX_W-1:0]   rsp_entry_index
);
	import slts_pkg::*;

	`SLTS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready, "block stayed ready after taking a beat")
	`SLTS_ASSERT_IMP(a_miss_index_zero, clk, arst_n, rsp_valid && !rsp_found, rsp_entry_index == '0, "entry_index nonzero without a hit")
	`SLTS_ASSERT_IMP(a_find_no_relation, clk, arst_n, rsp_valid && rsp_found, rsp_relation == REL_EQUAL, "find result carries a relation")
	`SLTS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_relation) && $stable(rsp_found) && $stable(rsp_entry_index), "stalled response beat changed")

endmodule

bind security_label_target_select slts_port_checker u_slts_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_relation    (rsp.relation),
	.rsp_found       (rsp.found),
	.rsp_entry_index (rsp.entry_index)
);

[verif/slts_checker.sv]
// Response checker for the security label target select block: predicts each beat and compares.
module slts_checker (
	input  logic clk,
	input  logic arst_n,
	slts_req_if  req,
	slts_rsp_if  rsp,
	slts_cfg_if  cfg,
	output int   fail_count,
	output int   pending_count,
	output int   checked_count,
	output int   hit_count
);
	import slts_pkg::*;

	typedef struct packed {
		rel_t               relation;
		logic               found;
		logic [INDEX_W-1:0] entry_index;
	} lookup_result_t;

	lookup_result_t       pending_results[$];
	logic [LABEL_W-1:0]   slot_label [DEF_TABLE_DEPTH];
	logic [DEF_TABLE_DEPTH-1:0] slot_valid;
	logic [DIMS_W-1:0]    dims_reg;

	function automatic rel_t label_relation(input logic [LABEL_W-1:0] a, input logic [LABEL_W-1:0] b,
		input logic [DIMS_W-1:0] dims_cfg);
		int dims;
		int n_eq;
		int n_below;
		int n_above;
		logic [DEF_CODE_BITS-1:0] x;
		logic [DEF_CODE_BITS-1:0] y;
		dims = (dims_cfg > DEF_MAX_DIMS) ? DEF_MAX_DIMS : int'(dims_cfg);
		n_eq = 0;
		n_below = 0;
		n_above = 0;
		// An empty label relates to nothing.
		if (dims == 0)
			return REL_NONE;
		for (int i = 0; i < dims; i++) begin
			x = a[i*DEF_CODE_BITS +: DEF_CODE_BITS];
			y = b[i*DEF_CODE_BITS +: DEF_CODE_BITS];
			if (x == y)
				n_eq++;
			else if (x == CODE_BOTTOM || y == CODE_TOP)
				n_below++;
			else if (x == CODE_TOP || y == CODE_BOTTOM)
				n_above++;
			else
				return REL_NONE;
		end
		if (n_eq == dims)
			return REL_EQUAL;
		if (n_eq + n_below == dims)
			return REL_BELOW;
		if (n_eq + n_above == dims)
			return REL_ABOVE;
		return REL_NONE;
	endfunction

	function automatic lookup_result_t predict_result(input op_t op, input logic [LABEL_W-1:0] a,
		input logic [LABEL_W-1:0] b);
		lookup_result_t res;
		logic [LABEL_W-1:0] best;
		rel_t r;
		res = '0;
		best = '0;
		case (op)
			OP_CMP: begin
				res.relation = label_relation(a, b, dims_reg);
			end
			OP_FIND: begin
				// A later candidate wins only when the kept one lies strictly above it.
				for (int i = 0; i < DEF_TABLE_DEPTH; i++) begin
					if (!slot_valid[i])
						continue;
					r = label_relation(a, slot_label[i], dims_reg);
					if (r != REL_EQUAL && r != REL_BELOW)
						continue;
					if (!res.found || label_relation(best, slot_label[i], dims_reg) == REL_ABOVE) begin
						best = slot_label[i];
						res.entry_index = i[INDEX_W-1:0];
						res.found = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	initial begin
		fail_count = 0;
		pending_count = 0;
		checked_count = 0;
		hit_count = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		lookup_result_t got;
		if (!arst_n) begin
			dims_reg = DIMS_RESET;
			slot_valid = '0;
			pending_results.delete();
		end else begin
			if (cfg.valid && cfg.ready)
				dims_reg = cfg.active_dims;
			if (req.valid && req.ready) begin
				pending_results.insert(pending_results.size(),
					predict_result(req.opcode, req.label_a, req.label_b));
				if (req.opcode == OP_STORE) begin
					slot_label[req.index] = req.label_a;
					slot_valid[req.index] = 1'b1;
				end else if (req.opcode == OP_CLEAR) begin
					slot_valid = '0;
				end
			end
			if (rsp.valid && rsp.ready) begin
				got.relation = rsp.relation;
				got.found = rsp.found;
				got.entry_index = rsp.entry_index;
				if (pending_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected response beat relation=%0d found=%0d entry_index=%0d",
						$time, got.relation, got.found, got.entry_index);
				end else begin
					want = pending_results.pop_front();
					checked_count++;
					if (want.found)
						hit_count++;
					if (got.relation !== want.relation || got.found !== want.found ||
						got.entry_index !== want.entry_index) begin
						fail_count++;
						$display("%0t: mismatch expected relation=%0d found=%0d entry_index=%0d, actual relation=%0d found=%0d entry_index=%0d",
							$time, want.relation, want.found, want.entry_index,
							got.relation, got.found, got.entry_index);
					end
				end
			end
		end
		pending_count = pending_results.size();
	end

endmodule

[verif/tb_security_label_target_select.sv]
// Testbench top for the security label target select block: stimulus, pacing and verdict.
module tb_security_label_target_select;
	import slts_pkg::*;

	localparam int PHASES         = 6;
	localparam int ITEMS_PER_PHASE = 90;
	localparam int LONG_HOLD      = 300;
	localparam int IDLE_LIMIT     = 4000;
	localparam int TAIL_CYCLES    = 40;

	logic clk;
	logic arst_n;

	slts_req_if req_ch();
	slts_rsp_if rsp_ch();
	slts_cfg_if cfg_ch();

	int fail_count;
	int pending_count;
	int checked_count;
	int hit_count;

	int send_idle_pct;
	int rsp_stall_pct;
	int hold_requests;
	int holds_done;
	int op_count [4];
	int cfg_count;
	int idle_cycles;

	logic [LABEL_W-1:0] slot_shadow [DEF_TABLE_DEPTH];
	logic [DEF_TABLE_DEPTH-1:0] slot_written;

	security_label_target_select u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	slts_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.cfg           (cfg_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count),
		.hit_count     (hit_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Biased toward bottom, top and two plain codes so that relations other than incomparable show up.
	function automatic logic [LABEL_W-1:0] random_label();
		logic [LABEL_W-1:0] lab;
		int r;
		if ($urandom_range(99) < 15)
			return $urandom;
		for (int i = 0; i < DEF_MAX_DIMS; i++) begin
			r = $urandom_range(9);
			if (r < 3)
				lab[i*DEF_CODE_BITS +: DEF_CODE_BITS] = DEF_CODE_BITS'(CODE_BOTTOM);
			else if (r < 6)
				lab[i*DEF_CODE_BITS +: DEF_CODE_BITS] = DEF_CODE_BITS'(CODE_TOP);
			else if (r < 9)
				lab[i*DEF_CODE_BITS +: DEF_CODE_BITS] = DEF_CODE_BITS'($urandom_range(3, 2));
			else
				lab[i*DEF_CODE_BITS +: DEF_CODE_BITS] = DEF_CODE_BITS'($urandom_range(15));
		end
		return lab;
	endfunction

	// Pushes some components to one code: bottom lowers the label, top raises it.
	function automatic logic [LABEL_W-1:0] nudge_label(input logic [LABEL_W-1:0] lab,
		input logic [DEF_CODE_BITS-1:0] code);
		for (int i = 0; i < DEF_MAX_DIMS; i++)
			if ($urandom_range(99) < 30)
				lab[i*DEF_CODE_BITS +: DEF_CODE_BITS] = code;
		return lab;
	endfunction

	task automatic send_item(input op_t op, input logic [INDEX_W-1:0] idx,
		input logic [LABEL_W-1:0] a, input logic [LABEL_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.opcode  <= op;
		req_ch.index   <= idx;
		req_ch.label_a <= a;
		req_ch.label_b <= b;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
		op_count[int'(op)]++;
		if (op == OP_STORE) begin
			slot_shadow[idx] = a;
			slot_written[idx] = 1'b1;
		end else if (op == OP_CLEAR) begin
			slot_written = '0;
		end
	endtask

	// Lets every outstanding beat come back before anything else happens.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_dims(input logic [DIMS_W-1:0] dims);
		wait_drained();
		cfg_ch.valid       <= 1'b1;
		cfg_ch.active_dims <= dims;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		cfg_count++;
	endtask

	// Receiver pacing; a hold request keeps ready low for a long stretch.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				holds_done++;
			end
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles, %0d responses outstanding",
					$time, IDLE_LIMIT, pending_count);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [DIMS_W-1:0] phase_dims [PHASES];
		op_t op;
		logic [INDEX_W-1:0] idx;
		logic [LABEL_W-1:0] la;
		logic [LABEL_W-1:0] lb;
		int r;
		int s;

		arst_n = 1'b0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_requests = 0;
		holds_done = 0;
		cfg_count = 0;
		idle_cycles = 0;
		slot_written = '0;
		foreach (op_count[i])
			op_count[i] = 0;
		req_ch.valid       <= 1'b0;
		req_ch.opcode      <= OP_STORE;
		req_ch.index       <= '0;
		req_ch.label_a     <= '0;
		req_ch.label_b     <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.active_dims <= DIMS_RESET;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset setting of eight components.
		send_item(OP_FIND, 4'd0, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_CMP,  4'd0, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_CMP,  4'd0, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(OP_CMP,  4'd0, 32'h1111_1111, 32'h0000_0000);
		send_item(OP_CMP,  4'd0, 32'h2222_2222, 32'h3333_3333);
		send_item(OP_CMP,  4'd0, 32'h1111_1111, 32'h2222_2222);
		send_item(OP_CMP,  4'd0, 32'h0000_0001, 32'h0000_0100);
		send_item(OP_STORE, 4'd0,  32'hFFFF_FFFF, 32'h0000_0000);
		send_item(OP_STORE, 4'd15, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(OP_STORE, 4'd5,  32'h1111_1111, 32'h0000_0000);
		send_item(OP_STORE, 4'd7,  32'h2222_1111, 32'h0000_0000);
		send_item(OP_STORE, 4'd9,  32'h2222_1111, 32'h0000_0000);
		send_item(OP_FIND, 4'd0, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_FIND, 4'd0, 32'h2222_0000, 32'h0000_0000);
		send_item(OP_FIND, 4'd0, 32'h1111_1111, 32'h0000_0000);
		send_item(OP_FIND, 4'd0, 32'h3333_3333, 32'h0000_0000);
		send_item(OP_CLEAR, 4'd0, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_FIND, 4'd0, 32'h0000_0000, 32'h0000_0000);
		// A single active component ignores everything above it.
		write_dims(4'd1);
		send_item(OP_CMP,   4'd0, 32'h0000_0002, 32'h3333_3332);
		send_item(OP_STORE, 4'd3, 32'hABCD_EF01, 32'h0000_0000);
		send_item(OP_FIND,  4'd0, 32'h0000_0000, 32'h0000_0000);
		// No active component: nothing relates and nothing is found.
		write_dims(4'd0);
		send_item(OP_CMP,  4'd0, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_FIND, 4'd0, 32'h0000_0000, 32'h0000_0000);
		// Counts above the maximum saturate.
		write_dims(4'd15);
		send_item(OP_CMP,  4'd0, 32'h0000_0000, 32'h1111_1111);
		send_item(OP_FIND, 4'd0, 32'h0000_0000, 32'h0000_0000);

		phase_dims[0] = 4'd8;
		phase_dims[1] = 4'd1;
		phase_dims[2] = 4'd15;
		phase_dims[3] = 4'd0;
		phase_dims[4] = 4'd4;
		phase_dims[5] = DIMS_W'($urandom_range(7, 2));

		for (int p = 0; p < PHASES; p++) begin
			write_dims(phase_dims[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
				1: begin send_idle_pct = 70; rsp_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rsp_stall_pct = 70; end
				default: begin send_idle_pct = 24; rsp_stall_pct = 24; end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// The receiver stops for a long while as the sender keeps offering beats.
				if (p == 4 && i == 20)
					hold_requests++;
				if (i == 45)
					wait_drained();
				idx = INDEX_W'($urandom_range(15));
				lb = $urandom;
				r = $urandom_range(99);
				if (r < 30) begin
					op = OP_STORE;
					la = random_label();
				end else if (r < 34) begin
					op = OP_CLEAR;
					la = $urandom;
				end else if (r < 64) begin
					op = OP_CMP;
					la = random_label();
					s = $urandom_range(9);
					if (s < 2)
						lb = nudge_label(la, DEF_CODE_BITS'(CODE_BOTTOM));
					else if (s < 4)
						lb = nudge_label(la, DEF_CODE_BITS'(CODE_TOP));
					else if (s < 5)
						lb = la;
					else if (s < 8)
						lb = random_label();
				end else begin
					op = OP_FIND;
					if (slot_written != '0 && $urandom_range(99) < 70) begin
						s = $urandom_range(15);
						while (!slot_written[s])
							s = $urandom_range(15);
						la = nudge_label(slot_shadow[s], DEF_CODE_BITS'(CODE_BOTTOM));
					end else begin
						la = random_label();
					end
				end
				send_item(op, idx, la, lb);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Summary: %0d requests (%0d store, %0d clear, %0d compare, %0d find), %0d active_dims writes",
			op_count[0] + op_count[1] + op_count[2] + op_count[3],
			op_count[0], op_count[1], op_count[2], op_count[3], cfg_count);
		$display("Summary: %0d responses checked, %0d finds returned a slot, pacing from none to 70 percent",
			checked_count, hit_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
